// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

// ===== src/mrsi_pkg.sv =====
// Shared types and constants of the multi-region spectrum integrator.
// Depends on nothing; used by every module of the block.
package mrsi_pkg;

    localparam int REGION_COUNT_DEF = 4;
    localparam int MAX_POINTS_DEF   = 65536;

    localparam int NUM_REGIONS = 4;
    localparam int REG_COUNT   = 2 * NUM_REGIONS;
    localparam int REG_IDX_W   = $clog2(REG_COUNT);
    localparam int ADDR_W      = REG_IDX_W + 2;
    localparam int APB_DATA_W  = 32;

    localparam int SAMPLE_W = 24;
    localparam int SUM_W    = 40;
    localparam int BOUND_W  = 16;
    localparam int CMP_W    = BOUND_W + 1;

    typedef logic [BOUND_W-1:0]         t_bound;
    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic [CMP_W-1:0]           t_cmp_idx;

    typedef struct packed {
        logic fire;
        logic last;
        logic live;
    } t_lane_ctl;

endpackage

// ===== src/mrsi_cfg.sv =====
// APB register file holding the start and end bound of each region.
// Depends on mrsi_pkg.
module mrsi_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mrsi_pkg::ADDR_W-1:0]       paddr,
    input  logic [mrsi_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mrsi_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output mrsi_pkg::t_bound                  o_start [mrsi_pkg::NUM_REGIONS],
    output mrsi_pkg::t_bound                  o_end   [mrsi_pkg::NUM_REGIONS]
);
    import mrsi_pkg::*;

    t_bound               r_regs [REG_COUNT];
    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_wr;

    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = APB_DATA_W'(r_regs[w_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= '0;
            end
        end else if (w_wr && pready) begin
            r_regs[w_idx] <= pwdata[BOUND_W-1:0];
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_REGIONS; r++) begin
            o_start[r] = r_regs[2*r];
            o_end[r]   = r_regs[2*r+1];
        end
    end

endmodule

// ===== src/mrsi_lane.sv =====
// One region lane: bound ordering, index window test and 40-bit accumulator.
// Depends on mrsi_pkg.
module mrsi_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mrsi_pkg::t_lane_ctl  i_ctl,
    input  mrsi_pkg::t_cmp_idx   i_idx,
    input  mrsi_pkg::t_sample    i_sample,
    input  mrsi_pkg::t_bound     i_start,
    input  mrsi_pkg::t_bound     i_end,
    output mrsi_pkg::t_sum       o_sum,
    output mrsi_pkg::t_bound     o_hi
);
    import mrsi_pkg::*;

    t_sum   r_acc;
    t_sum   n_acc;
    t_sum   w_sext;
    t_bound w_lo;
    logic   w_hit;

    assign w_lo   = (i_end < i_start) ? i_end : i_start;
    assign o_hi   = (i_end < i_start) ? i_start : i_end;
    assign w_hit  = i_ctl.live && (i_idx >= CMP_W'(w_lo)) && (i_idx < CMP_W'(o_hi));
    assign w_sext = {{(SUM_W-SAMPLE_W){i_sample[SAMPLE_W-1]}}, i_sample};
    assign o_sum  = w_hit ? t_sum'(r_acc + w_sext) : r_acc;
    assign n_acc  = i_ctl.last ? '0 : o_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.fire) begin
            r_acc <= n_acc;
        end
    end

endmodule

// ===== src/multi_region_spectrum_integrator_core.sv =====
// Top level of the multi-region spectrum integrator: input register, region lanes,
// result register. Depends on mrsi_pkg, mrsi_cfg, mrsi_lane and assert_macros.svh.
//
//   channel | handshake                   | words
//   --------+-----------------------------+------------------------------------
//   input   | i_in_valid / o_in_ready     | i_sample_real, i_last_point
//   output  | o_out_valid / i_out_ready   | o_region0..3_sum, o_too_short
//   config  | psel penable pwrite / pready| paddr, pwdata, prdata
//
// One word accepted per cycle unless a last word waits on a stalled result. Each word
// passes the input register and one add per region; last sums load the result register.
// Synchronous active-low reset clears bounds, index, accumulators and valids.
// A stalled result holds the output register; only a last word then waits in the
// input register, while non-last words keep flowing.
`include "assert_macros.svh"

module multi_region_spectrum_integrator_core #(
    parameter int REGION_COUNT = mrsi_pkg::REGION_COUNT_DEF,
    parameter int MAX_POINTS   = mrsi_pkg::MAX_POINTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  mrsi_pkg::t_sample               i_sample_real,
    input  logic                            i_last_point,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output mrsi_pkg::t_sum                  o_region0_sum,
    output mrsi_pkg::t_sum                  o_region1_sum,
    output mrsi_pkg::t_sum                  o_region2_sum,
    output mrsi_pkg::t_sum                  o_region3_sum,
    output logic                            o_too_short,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mrsi_pkg::ADDR_W-1:0]     paddr,
    input  logic [mrsi_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mrsi_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import mrsi_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS + 1);

    t_bound     w_start [NUM_REGIONS];
    t_bound     w_end   [NUM_REGIONS];
    t_sum       w_sum   [NUM_REGIONS];
    t_bound     w_hi    [NUM_REGIONS];
    t_bound     w_maxend;

    logic       r_in_valid;
    t_sample    r_in_sample;
    logic       r_in_last;

    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic       w_live;
    logic       w_out_free;
    logic       w_fire;
    t_lane_ctl  w_ctl;

    logic       r_out_valid;
    t_sum       r_out_sum [NUM_REGIONS];
    logic       r_out_short;

    mrsi_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_start (w_start),
        .o_end   (w_end)
    );

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && (!r_in_last || w_out_free);
    assign o_in_ready = !r_in_valid || w_fire;

    assign w_live = r_idx < IDX_W'(MAX_POINTS);
    assign n_idx  = w_live ? IDX_W'(r_idx + 1'b1) : r_idx;

    assign w_ctl.fire = w_fire;
    assign w_ctl.last = r_in_last;
    assign w_ctl.live = w_live;

    for (genvar g = 0; g < NUM_REGIONS; g++) begin : g_lane
        if (g < REGION_COUNT) begin : g_on
            mrsi_lane u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_idx    (CMP_W'(r_idx)),
                .i_sample (r_in_sample),
                .i_start  (w_start[g]),
                .i_end    (w_end[g]),
                .o_sum    (w_sum[g]),
                .o_hi     (w_hi[g])
            );
        end else begin : g_off
            assign w_sum[g] = '0;
            assign w_hi[g]  = '0;
        end
    end

    always_comb begin
        w_maxend = '0;
        for (int r = 0; r < NUM_REGIONS; r++) begin
            if (w_hi[r] > w_maxend) begin
                w_maxend = w_hi[r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_sample <= i_sample_real;
            r_in_last   <= i_last_point;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (w_fire) begin
            r_idx <= r_in_last ? '0 : n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in_last) begin
            r_out_sum   <= w_sum;
            r_out_short <= CMP_W'(n_idx) <= CMP_W'(w_maxend);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_region0_sum = r_out_sum[0];
    assign o_region1_sum = r_out_sum[1];
    assign o_region2_sum = r_out_sum[2];
    assign o_region3_sum = r_out_sum[3];
    assign o_too_short   = r_out_short;

    `ASSERT_CLK(a_idx_range, i_clk, i_rst_n, r_idx <= IDX_W'(MAX_POINTS))
    `ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, w_fire && r_in_last, o_out_valid && (r_idx == '0))
    `ASSERT_NEXT(a_no_result_midstream, i_clk, i_rst_n, w_fire && !r_in_last && !r_out_valid, !o_out_valid)

endmodule
